// File: design/pwgfd_pkg.sv
// Shared types, constants and helpers for the pulse-width gamepad frame decoder.
// No dependencies; every other design file imports this package.
package pwgfd_pkg;

  localparam int unsigned FRAME_BITS_DEF = 18;
  localparam int unsigned TICK_W         = 8;
  localparam int unsigned WORD_W         = 16;
  localparam int unsigned MAP_W          = 12;
  localparam int unsigned HOLD_W         = 4;
  localparam int unsigned NIB_W          = 4;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 8;

  localparam logic [TICK_W-1:0] PREAMBLE_MIN_RST = 8'd34;
  localparam logic [TICK_W-1:0] PREAMBLE_MAX_RST = 8'd38;
  localparam logic [TICK_W-1:0] SHORT_MIN_RST    = 8'd2;
  localparam logic [TICK_W-1:0] SHORT_MAX_RST    = 8'd6;
  localparam logic [TICK_W-1:0] LONG_MIN_RST     = 8'd11;
  localparam logic [TICK_W-1:0] LONG_MAX_RST     = 8'd15;
  localparam logic [HOLD_W-1:0] HOLD_POLLS_RST   = 4'd10;

  localparam logic MODE_PULSE = 1'b0;
  localparam logic MODE_POLL  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PREAMBLE_MIN = 3'd0,
    CFG_PREAMBLE_MAX = 3'd1,
    CFG_SHORT_MIN    = 3'd2,
    CFG_SHORT_MAX    = 3'd3,
    CFG_LONG_MIN     = 3'd4,
    CFG_LONG_MAX     = 3'd5,
    CFG_HOLD_POLLS   = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [TICK_W-1:0] preamble_min;
    logic [TICK_W-1:0] preamble_max;
    logic [TICK_W-1:0] short_min;
    logic [TICK_W-1:0] short_max;
    logic [TICK_W-1:0] long_min;
    logic [TICK_W-1:0] long_max;
    logic [HOLD_W-1:0] hold_polls;
  } cfg_t;

  // Outcome of one pulse beat, handed from the frame receiver to the poll side.
  typedef struct packed {
    logic              latched;
    logic              error;
    logic [WORD_W-1:0] word;
  } pulse_evt_t;

  function automatic logic in_window(input logic [TICK_W-1:0] t,
                                     input logic [TICK_W-1:0] lo,
                                     input logic [TICK_W-1:0] hi);
    in_window = (t >= lo) && (t <= hi);
  endfunction

endpackage

// File: design/pwgfd_cfg_regs.sv
// Configuration register file for the frame decoder.
// Depends on pwgfd_pkg for the register map and the cfg_t bundle.
module pwgfd_cfg_regs
  import pwgfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PREAMBLE_MIN: cfg_nxt.preamble_min = cfg_data;
        CFG_PREAMBLE_MAX: cfg_nxt.preamble_max = cfg_data;
        CFG_SHORT_MIN:    cfg_nxt.short_min    = cfg_data;
        CFG_SHORT_MAX:    cfg_nxt.short_max    = cfg_data;
        CFG_LONG_MIN:     cfg_nxt.long_min     = cfg_data;
        CFG_LONG_MAX:     cfg_nxt.long_max     = cfg_data;
        CFG_HOLD_POLLS:   cfg_nxt.hold_polls   = cfg_data[HOLD_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.preamble_min <= PREAMBLE_MIN_RST;
      cfg_r.preamble_max <= PREAMBLE_MAX_RST;
      cfg_r.short_min    <= SHORT_MIN_RST;
      cfg_r.short_max    <= SHORT_MAX_RST;
      cfg_r.long_min     <= LONG_MIN_RST;
      cfg_r.long_max     <= LONG_MAX_RST;
      cfg_r.hold_polls   <= HOLD_POLLS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: design/pwgfd_pulse_rx.sv
// Pulse-width frame receiver: bit position counter and shift register.
// Depends on pwgfd_pkg for widths, cfg_t, pulse_evt_t and in_window.
module pwgfd_pulse_rx
  import pwgfd_pkg::*;
#(
  parameter int unsigned FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [TICK_W-1:0] ticks,
  input  logic              level,
  input  cfg_t              cfg,
  output pulse_evt_t        evt
);

  localparam int unsigned POS_W = $clog2(FRAME_BITS + 2);
  localparam logic [POS_W-1:0] POS_IDLE = '0;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BITS + 1);

  logic [POS_W-1:0]  bit_pos_r, bit_pos_nxt;
  logic [WORD_W-1:0] shift_r, shift_nxt;
  logic              is_short, is_long, is_pre;

  always_comb begin
    is_short    = in_window(ticks, cfg.short_min, cfg.short_max);
    is_long     = in_window(ticks, cfg.long_min, cfg.long_max);
    is_pre      = in_window(ticks, cfg.preamble_min, cfg.preamble_max);
    bit_pos_nxt = bit_pos_r;
    shift_nxt   = shift_r;
    evt         = '0;
    if (bit_pos_r == POS_IDLE) begin
      if (!level && is_pre) begin
        bit_pos_nxt = POS_W'(1);
      end
    end else if (level) begin
      // Shift first; a bad pulse still leaves the zero in place.
      shift_nxt = {shift_r[WORD_W-2:0], is_long};
      if (!is_long && !is_short) begin
        bit_pos_nxt = POS_IDLE;
        evt.error   = 1'b1;
      end else if (bit_pos_r + POS_W'(1) == POS_LAST) begin
        bit_pos_nxt = POS_IDLE;
        evt.latched = 1'b1;
      end else begin
        bit_pos_nxt = bit_pos_r + POS_W'(1);
      end
    end else if (!is_short) begin
      bit_pos_nxt = POS_IDLE;
      evt.error   = 1'b1;
    end
    evt.word = shift_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_pos_r <= POS_IDLE;
      shift_r   <= '0;
    end else if (step) begin
      bit_pos_r <= bit_pos_nxt;
      shift_r   <= shift_nxt;
    end
  end

endmodule

// File: design/pwgfd_player_track.sv
// Pending word, checksum check, per-player button maps and hold timers.
// Depends on pwgfd_pkg for widths and pulse_evt_t.
module pwgfd_player_track
  import pwgfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pulse_step,
  input  logic              poll_step,
  input  pulse_evt_t        evt,
  input  logic [HOLD_W-1:0] hold_polls,
  output logic [MAP_W-1:0]  map_one_nxt,
  output logic [MAP_W-1:0]  map_two_nxt,
  output logic              bad
);

  logic [WORD_W-1:0] pending_r, pending_nxt;
  logic [MAP_W-1:0]  map_r   [2];
  logic [MAP_W-1:0]  map_nxt [2];
  logic [HOLD_W-1:0] timer_r   [2];
  logic [HOLD_W-1:0] timer_nxt [2];
  logic [MAP_W-1:0]  btn;
  logic [NIB_W-1:0]  chk, nib_sum;

  assign btn     = pending_r[WORD_W-1:NIB_W];
  assign chk     = pending_r[NIB_W-1:0];
  assign nib_sum = btn[3:0] + btn[7:4] + btn[11:8];

  always_comb begin
    pending_nxt = pending_r;
    map_nxt     = map_r;
    timer_nxt   = timer_r;
    bad         = 1'b0;
    if (pulse_step && evt.latched) begin
      pending_nxt = evt.word;
    end
    if (poll_step) begin
      if (pending_r != '0) begin
        if (nib_sum + NIB_W'(1) == chk) begin
          map_nxt[0]   = btn;
          timer_nxt[0] = hold_polls;
        end else if (nib_sum - NIB_W'(1) == chk) begin
          map_nxt[1]   = btn;
          timer_nxt[1] = hold_polls;
        end else begin
          bad = 1'b1;
        end
        pending_nxt = '0;
      end else begin
        // Age each timer; clear the map when it runs out.
        for (int p = 0; p < 2; p++) begin
          if (timer_r[p] != '0) begin
            timer_nxt[p] = timer_r[p] - HOLD_W'(1);
            if (timer_r[p] == HOLD_W'(1)) begin
              map_nxt[p] = '0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      map_r     <= '{default: '0};
      timer_r   <= '{default: '0};
    end else begin
      pending_r <= pending_nxt;
      map_r     <= map_nxt;
      timer_r   <= timer_nxt;
    end
  end

  assign map_one_nxt = map_nxt[0];
  assign map_two_nxt = map_nxt[1];

endmodule

// File: design/pulse_width_gamepad_frame_decoder_core.sv
// Top level of the pulse-width gamepad frame decoder.
// Depends on pwgfd_pkg, pwgfd_cfg_regs, pwgfd_pulse_rx and pwgfd_player_track.
//
// Each input beat is either a measured pulse (mode 0: width in ticks and level)
// or a poll tick (mode 1), and it yields exactly one result beat carrying both
// players' button maps after that beat plus three event flags. A low pulse in
// the preamble window opens a frame; each high pulse then shifts in one bit
// (long window = 1, short window = 0, long wins where they overlap) and each
// low pulse must be short, otherwise the frame aborts with framing_error.
// After FRAME_BITS bits the low 16 bits become the pending word and
// frame_latched is set. A poll consumes a nonzero pending word: its checksum
// nibble picks player one (nibble sum + 1) or player two (nibble sum - 1), or
// the word is dropped with checksum_bad. A poll with nothing pending ages the
// hold timers and clears a player's map when its timer expires; hold_polls of
// zero holds a map until that player's next frame. Throughput is one beat per
// clock unless the consumer stalls; a beat passes input and result registers,
// and the state update loop through the window compares and checksum adder
// sets the rate. The user must write registers through cfg_we/cfg_index/
// cfg_data only while no beat is in flight; the block does not enforce this.
// An index beyond the register list is ignored. No clearing pass after reset.
module pulse_width_gamepad_frame_decoder_core
  import pwgfd_pkg::*;
#(
  parameter int unsigned FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [TICK_W-1:0]     in_pulse_ticks,
  input  logic                  in_level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [MAP_W-1:0]      out_player_one_buttons,
  output logic [MAP_W-1:0]      out_player_two_buttons,
  output logic                  out_frame_latched,
  output logic                  out_framing_error,
  output logic                  out_checksum_bad,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t              cfg;
  pulse_evt_t        evt;

  // Input register stage.
  logic              s1_valid_r;
  logic              s1_mode_r;
  logic [TICK_W-1:0] s1_ticks_r;
  logic              s1_level_r;

  // Result register stage.
  logic              out_valid_r;
  logic [MAP_W-1:0]  out_one_r, out_two_r;
  logic              out_latched_r, out_error_r, out_bad_r;

  logic              advance;
  logic              pulse_step, poll_step;
  logic [MAP_W-1:0]  map_one_nxt, map_two_nxt;
  logic              bad;

  // Move the held beat into the result register when that slot is free or
  // being drained this cycle; state commits at the same edge.
  assign advance    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || advance;
  assign pulse_step = advance && (s1_mode_r == MODE_PULSE);
  assign poll_step  = advance && (s1_mode_r == MODE_POLL);

  pwgfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pwgfd_pulse_rx #(
    .FRAME_BITS (FRAME_BITS)
  ) u_pulse_rx (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (pulse_step),
    .ticks (s1_ticks_r),
    .level (s1_level_r),
    .cfg   (cfg),
    .evt   (evt)
  );

  pwgfd_player_track u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .pulse_step  (pulse_step),
    .poll_step   (poll_step),
    .evt         (evt),
    .hold_polls  (cfg.hold_polls),
    .map_one_nxt (map_one_nxt),
    .map_two_nxt (map_two_nxt),
    .bad         (bad)
  );

  // Input register: capture on each accepted beat, drop valid once consumed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode_r  <= in_mode;
      s1_ticks_r <= in_pulse_ticks;
      s1_level_r <= in_level;
    end
  end

  // Result register: hold while the consumer stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_one_r     <= map_one_nxt;
      out_two_r     <= map_two_nxt;
      out_latched_r <= pulse_step && evt.latched;
      out_error_r   <= pulse_step && evt.error;
      out_bad_r     <= poll_step && bad;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_player_one_buttons = out_one_r;
  assign out_player_two_buttons = out_two_r;
  assign out_frame_latched      = out_latched_r;
  assign out_framing_error      = out_error_r;
  assign out_checksum_bad       = out_bad_r;

`ifndef ASSERT_OFF
  // An empty result slot must never hold off the producer.
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty result register");

  // A full pipeline with a stalled consumer must back-pressure the input.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input accepted while pipeline is full and stalled");

  // Pulse flags and the poll flag come from different beat kinds.
  a_flag_kinds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_frame_latched || out_framing_error)) |-> !out_checksum_bad)
    else $error("pulse and poll flags set on one result beat");

  // A beat reaching the result register always follows an accepted input beat.
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result beat without an input beat");
`endif

endmodule
